// ===== rtl/core/sis_pkg.sv =====
// shared types and constants for the sorted integer set
package sis_pkg;

  localparam int ValueWidth = 32;
  localparam int OutWidth   = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // per-cycle controls broadcast to every cell of the chain
  typedef struct packed {
    logic compare;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/sis_if.sv =====
// valid/ready channel interfaces for request and result words
interface sis_in_if;
  import sis_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [ValueWidth-1:0] value;
  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

interface sis_out_if;
  import sis_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [OutWidth-1:0] position;
  logic [OutWidth-1:0] count;
  logic                full_error;
  modport source (output valid, output found, output position, output count,
                  output full_error, input ready);
  modport sink (input valid, input found, input position, input count,
                input full_error, output ready);
endinterface

// ===== rtl/core/sorted_integer_set_unit.sv =====
// sorted integer set top level: chain of cells, control and result register
// an accepted word is compared in all cells, then a commit step shifts the chain
// on an insert and registers the result; the next word is accepted only after
// the commit step, and a stalled result holds the commit step and so that accept
// reset clears the cell valid flags, the element count and the result valid;
// stored entries are not cleared
module sorted_integer_set_unit #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  sis_in_if.sink    in_ch,
  sis_out_if.source out_ch
);
  import sis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_t;

  state_t state, state_next;

  logic                         action_q;
  logic signed [ValueWidth-1:0] value_q;
  logic [CW-1:0]                cnt_q;

  logic signed [ValueWidth-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]          vld, gt, eq;
  cell_ctrl_t                   cell_ctrl;

  logic          accept, out_free, commit, insert_go, found_c, full_c;
  logic [CW-1:0] pos_oh, pos_c, cnt_c;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign commit      = (state == S_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_COMMIT;
      S_COMMIT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= in_ch.action;
      value_q  <= in_ch.value;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [ValueWidth-1:0] l_ent;
      logic                         l_vld, l_gt;
      if (g == 0) begin : g_head
        assign l_ent = '0;
        assign l_vld = 1'b1;
        assign l_gt  = 1'b1;
      end else begin : g_body
        assign l_ent = ent[g-1];
        assign l_vld = vld[g-1];
        assign l_gt  = gt[g-1];
      end
      sis_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (cell_ctrl),
        .cmp_value  (in_ch.value),
        .ins_value  (value_q),
        .left_entry (l_ent),
        .left_valid (l_vld),
        .left_gt    (l_gt),
        .entry      (ent[g]),
        .valid      (vld[g]),
        .gt         (gt[g]),
        .eq         (eq[g])
      );
    end
  endgenerate

  // the greater-than flags form a thermometer; its edge is the search position
  always_comb begin
    logic left;
    pos_oh  = '0;
    found_c = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      left = (i == 0) ? 1'b1 : gt[i-1];
      if (left && !gt[i]) begin
        pos_oh  = pos_oh | CW'(i);
        found_c = found_c | eq[i];
      end
    end
  end

  assign pos_c     = gt[CAPACITY-1] ? CW'(CAPACITY) : pos_oh;
  assign full_c    = vld[CAPACITY-1];
  assign insert_go = commit && (action_q == ACT_INSERT) && !found_c && !full_c;
  assign cnt_c     = insert_go ? cnt_q + CW'(1) : cnt_q;

  assign cell_ctrl.compare = accept;
  assign cell_ctrl.shift   = insert_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (commit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.found      <= found_c;
      out_ch.position   <= OutWidth'(pos_c);
      out_ch.count      <= OutWidth'(cnt_c);
      out_ch.full_error <= (action_q == ACT_INSERT) && !found_c && full_c;
    end
  end

endmodule

// ===== rtl/core/sis_cell.sv =====
// one cell of the sorted chain: holds one entry, compares and shifts
module sis_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sis_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [sis_pkg::ValueWidth-1:0] cmp_value,
  input  logic signed [sis_pkg::ValueWidth-1:0] ins_value,
  input  logic signed [sis_pkg::ValueWidth-1:0] left_entry,
  input  logic                                  left_valid,
  input  logic                                  left_gt,
  output logic signed [sis_pkg::ValueWidth-1:0] entry,
  output logic                                  valid,
  output logic                                  gt,
  output logic                                  eq
);
  import sis_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      gt <= valid && (entry > cmp_value);
      eq <= valid && (entry == cmp_value);
    end
  end

  // cells above the insertion point keep, the boundary cell takes the new word,
  // cells below take their left neighbor
  always_ff @(posedge clk) begin
    if (ctrl.shift && !gt) begin
      if (left_gt) begin
        entry <= ins_value;
      end else begin
        entry <= left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift && !gt) begin
      valid <= left_gt ? 1'b1 : left_valid;
    end
  end

endmodule

// ===== rtl/core/sis_checker.sv =====
// port-level assertions for the sorted integer set, bound to the top level
module sis_checker #(
  parameter int CAPACITY = 64
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               found,
  input logic [sis_pkg::OutWidth-1:0]       position,
  input logic [sis_pkg::OutWidth-1:0]       count,
  input logic                               full_error
);
  import sis_pkg::*;

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({found, position, count, full_error}))
    else $error("result word changed while stalled");

  // with the output free at the accept, a result follows the commit step
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // a refused insert never reports the value as present
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_error |-> !found)
    else $error("full error together with found");

  // for a capacity up to 127, the search position never passes the element count
  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CAPACITY > 127) || (position <= count))
    else $error("position beyond count");

endmodule

bind sorted_integer_set_unit sis_checker #(.CAPACITY(CAPACITY)) u_sis_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .found      (out_ch.found),
  .position   (out_ch.position),
  .count      (out_ch.count),
  .full_error (out_ch.full_error)
);
